// ----- hdl/bse_pkg.sv -----
// ----------------------------------------------------------------------------
// bse_pkg
// Shared constants and the command record for the byte string escaper.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int MaxChars          = 6;
  localparam int CharW             = 7;
  localparam int CountW            = 3;
  localparam int QueueDepthDefault = 4;

  localparam logic [CharW-1:0] ChQuote     = 7'h27;
  localparam logic [CharW-1:0] ChBackslash = 7'h5C;
  localparam logic [CharW-1:0] ChSpace     = 7'h20;
  localparam logic [CharW-1:0] ChTilde     = 7'h7E;
  localparam logic [CharW-1:0] ChZero      = 7'h30;
  localparam logic [CharW-1:0] ChLowerA    = 7'h61;
  localparam logic [CharW-1:0] ChX         = 7'h78;
  localparam logic [CharW-1:0] ChT         = 7'h74;
  localparam logic [CharW-1:0] ChN         = 7'h6E;
  localparam logic [CharW-1:0] ChR         = 7'h72;

  // One classified item: the characters to send, how many, and whether the
  // final one closes the text.
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [CountW-1:0]              count;
    logic                           close;
  } desc_t;

endpackage

// ----- hdl/bse_in_if.sv -----
// ----------------------------------------------------------------------------
// bse_in_if
// Input channel: one string byte per item with its framing flags.
// ----------------------------------------------------------------------------
interface bse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       empty_string;

  modport source (output valid, output data_byte, output last_byte,
                  output empty_string, input ready);
  modport sink   (input valid, input data_byte, input last_byte,
                  input empty_string, output ready);
endinterface

// ----- hdl/bse_out_if.sv -----
// ----------------------------------------------------------------------------
// bse_out_if
// Output channel: one printable character per item.
// ----------------------------------------------------------------------------
interface bse_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       end_of_text;

  modport source (output valid, output out_char, output end_of_text,
                  input ready);
  modport sink   (input valid, input out_char, input end_of_text,
                  output ready);
endinterface

// ----- hdl/bse_front.sv -----
// ----------------------------------------------------------------------------
// bse_front
// Accept bytes, track string framing and build the character list per item.
// ----------------------------------------------------------------------------
module bse_front (
  input  logic          clk,
  input  logic          rst,
  bse_in_if.sink        in_chan,
  output bse_pkg::desc_t push_data,
  output logic          push_valid,
  input  logic          push_ready
);
  import bse_pkg::*;

  logic              at_string_start;
  logic              close;
  logic [CountW-1:0] n;
  desc_t             desc;

  function automatic logic [CharW-1:0] hex_digit(input logic [3:0] v);
    logic [CharW-1:0] w;
    w = {3'b000, v};
    return (v < 4'd10) ? ChZero + w : ChLowerA + w - 7'd10;
  endfunction

  assign close = in_chan.empty_string | in_chan.last_byte;

  always_comb begin
    desc = '0;
    n    = '0;
    if (at_string_start) begin
      desc.chars[n] = ChQuote;
      n = n + 3'd1;
    end
    if (!in_chan.empty_string) begin
      priority if (in_chan.data_byte == 8'h09) begin
        desc.chars[n]        = ChBackslash;
        desc.chars[n + 3'd1] = ChT;
        n = n + 3'd2;
      end else if (in_chan.data_byte == 8'h0A) begin
        desc.chars[n]        = ChBackslash;
        desc.chars[n + 3'd1] = ChN;
        n = n + 3'd2;
      end else if (in_chan.data_byte == 8'h0D) begin
        desc.chars[n]        = ChBackslash;
        desc.chars[n + 3'd1] = ChR;
        n = n + 3'd2;
      end else if (in_chan.data_byte == {1'b0, ChQuote} ||
                   in_chan.data_byte == {1'b0, ChBackslash}) begin
        desc.chars[n]        = ChBackslash;
        desc.chars[n + 3'd1] = in_chan.data_byte[6:0];
        n = n + 3'd2;
      end else if (in_chan.data_byte >= {1'b0, ChSpace} &&
                   in_chan.data_byte <= {1'b0, ChTilde}) begin
        desc.chars[n] = in_chan.data_byte[6:0];
        n = n + 3'd1;
      end else begin
        desc.chars[n]        = ChBackslash;
        desc.chars[n + 3'd1] = ChX;
        desc.chars[n + 3'd2] = hex_digit(in_chan.data_byte[7:4]);
        desc.chars[n + 3'd3] = hex_digit(in_chan.data_byte[3:0]);
        n = n + 3'd4;
      end
    end
    if (close) begin
      desc.chars[n] = ChQuote;
      n = n + 3'd1;
    end
    desc.count = n;
    desc.close = close;
  end

  assign push_data     = desc;
  assign push_valid    = in_chan.valid;
  assign in_chan.ready = push_ready;

  // Re-arm the opening quote once a string closes.
  always_ff @(posedge clk) begin
    if (rst) begin
      at_string_start <= 1'b1;
    end else if (in_chan.valid && push_ready) begin
      at_string_start <= close;
    end
  end

endmodule

// ----- hdl/bse_queue.sv -----
// ----------------------------------------------------------------------------
// bse_queue
// Small FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module bse_queue #(
  parameter int DEPTH = bse_pkg::QueueDepthDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  bse_pkg::desc_t push_data,
  output logic           pop_valid,
  input  logic           pop,
  output bse_pkg::desc_t pop_data
);
  import bse_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  desc_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != FW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FW'(1);
      end
    end
  end

endmodule

// ----- hdl/bse_back.sv -----
// ----------------------------------------------------------------------------
// bse_back
// Walk the character list of the head item, one character per cycle when the output is not stalled.
// ----------------------------------------------------------------------------
module bse_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  bse_pkg::desc_t head,
  output logic           pop,
  bse_out_if.source      out_chan
);
  import bse_pkg::*;

  logic [CountW-1:0] idx;
  logic              out_valid;
  logic [CharW-1:0]  out_char;
  logic              out_eot;
  logic              load;
  logic              last_char;

  assign load      = head_valid && (!out_valid || out_chan.ready);
  assign last_char = (idx == head.count - 3'd1);
  assign pop       = load && last_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= last_char ? '0 : idx + 3'd1;
        out_valid <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: hold while stalled.
  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= head.chars[idx];
      out_eot  <= head.close && last_char;
    end
  end

  assign out_chan.valid       = out_valid;
  assign out_chan.out_char    = out_char;
  assign out_chan.end_of_text = out_eot;

endmodule

// ----- hdl/byte_string_escaper_top.sv -----
// ----------------------------------------------------------------------------
// byte_string_escaper_top
// Quote and escape a byte string, one byte in, one character out.
// ----------------------------------------------------------------------------
// Each input item is one byte of a string (or a marker for a whole empty
// string) and yields between one and six output characters: an opening
// quote before the first byte of a string, the byte itself or its escape
// (two characters for tab, newline, carriage return, quote and backslash,
// four for a hex escape), and a closing quote flagged by end_of_text after
// the byte marked last. The output port sends one character per cycle
// when it is not stalled; an item has six characters at worst, for a
// hex-escaped single-byte string. A front part classifies each byte the
// cycle it arrives and writes the result into a queue of QUEUE_DEPTH
// items; a back part drains the queue head one character per cycle, when
// not stalled, into a registered output. Input is taken every cycle while
// the queue has room, so short items arrive back to back while longer ones
// are still being sent, and the first character of an item passes through
// the queue and then the output register.
// ----------------------------------------------------------------------------
module byte_string_escaper_top #(
  parameter int QUEUE_DEPTH = bse_pkg::QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  bse_in_if.sink     in_chan,
  bse_out_if.source  out_chan
);
  import bse_pkg::*;

  desc_t push_data;
  logic  push_valid;
  logic  push_ready;
  desc_t head;
  logic  head_valid;
  logic  pop;

  // Front: accept, classify, track whether an opening quote is due.
  bse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_chan    (in_chan),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // Decouple: let the front keep taking bytes while the back sends.
  bse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (head_valid),
    .pop        (pop),
    .pop_data   (head)
  );

  // Back: send the head item's characters, drop it after the last one.
  bse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule

// ----- hdl/bse_checker.sv -----
// ----------------------------------------------------------------------------
// bse_checker
// Port-level checks on the escaper output, bound to the top level.
// ----------------------------------------------------------------------------
module bse_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_char,
  input logic       end_of_text
);

  // A stalled output item holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) &&
                                $stable(end_of_text))
    else $error("output item changed while stalled");

  // Only printable characters leave the block.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_char >= 7'h20 && out_char <= 7'h7E)
    else $error("non-printable character sent");

  // The end of text is always a closing quote.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_text |-> out_char == 7'h27)
    else $error("end_of_text on a character other than a quote");

  // Nothing is offered straight out of reset.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind byte_string_escaper_top bse_checker u_bse_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_char    (out_chan.out_char),
  .end_of_text (out_chan.end_of_text)
);
